// ===== rtl/msw_pkg.sv =====
// ----------------------------------------------------------------------------
// msw_pkg
// shared types, register indexes, reset values and helpers for the motion
// sleep/wake detector
// ----------------------------------------------------------------------------
package msw_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_MOTION_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_WAKE_THRESHOLD   = 2'd1;
	localparam logic [1:0] REG_IDLE_TIMEOUT_MS  = 2'd2;
	localparam logic [1:0] REG_WAKE_HITS_NEEDED = 2'd3;

	// register reset values
	localparam logic [13:0] MOTION_THRESHOLD_RST = 14'd80;
	localparam logic [13:0] WAKE_THRESHOLD_RST   = 14'd25;
	localparam logic [31:0] IDLE_TIMEOUT_MS_RST  = 32'd60000;
	localparam logic [7:0]  WAKE_HITS_NEEDED_RST = 8'd1;

	// filter shifts: gravity 1/16, wake reference 1/8
	localparam int unsigned GRAV_SHIFT = 4;
	localparam int unsigned REF_SHIFT  = 3;

	localparam logic [7:0] HIT_CNT_MAX = 8'hFF;

	typedef struct packed {
		logic [13:0] motion_threshold;
		logic [13:0] wake_threshold;
		logic [31:0] idle_timeout_ms;
		logic [7:0]  wake_hits_needed;
	} cfg_t;

	typedef struct packed {
		logic signed [11:0] accel_x;
		logic signed [11:0] accel_y;
		logic signed [11:0] accel_z;
		logic [31:0]        time_ms;
	} sample_t;

	typedef struct packed {
		logic [13:0] motion_norm;
		logic [13:0] wake_distance_mg;
		logic        sleeping;
		logic        entered_sleep;
		logic        woke_up;
		logic        sample_invalid;
	} result_t;

	// signed shift right that rounds toward zero
	function automatic logic signed [12:0] shr_trunc(input logic signed [12:0] d,
			input int unsigned sh);
		logic signed [12:0] bias;
		bias = 13'sd0;
		if (d < 0) begin
			bias = (13'sd1 <<< sh) - 13'sd1;
		end
		return (d + bias) >>> sh;
	endfunction

	function automatic logic [12:0] abs13(input logic signed [12:0] d);
		logic signed [12:0] n;
		n = -d;
		return (d < 0) ? 13'(n) : 13'(d);
	endfunction

endpackage

// ===== rtl/motion_sleep_wake_detector_unit.sv =====
// ----------------------------------------------------------------------------
// motion_sleep_wake_detector_unit
// accelerometer inactivity detector: tracks gravity, reports motion, enters
// sleep after an idle timeout and wakes on repeated reference deviation
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  s_tdata: accel_x, accel_y, accel_z, time_ms
//  m_*       out  m_tvalid/m_tready  m_tdata: motion, distance, flags; m_tuser: invalid
//  cfg_*     in   cfg_we             cfg_index, cfg_wdata (write only)
//
//  one sample per cycle sustained while m_tready keeps the result register
//  draining; an input beat passes the input register, then the result register
//  the state update is a single combinational pass of subtracts, shifts and
//  adds plus a 32 bit idle compare between the input and result registers
//  reset clears the detector state and loads register defaults; no clear pass
//  a stalled output holds its beat; the input register keeps accepting while
//  the result register is free or being drained
//
module motion_sleep_wake_detector_unit (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // accel_x[11:0], accel_y[23:12], accel_z[35:24],
	                               // time_ms[67:36], zero pad[71:68]

	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // motion_norm[13:0], wake_distance_mg[27:14],
	                               // sleeping[28], entered_sleep[29], woke_up[30],
	                               // zero pad[31]
	output logic        m_tuser,   // sample_invalid

	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);

	msw_pkg::cfg_t    cfg_q;
	msw_pkg::sample_t sample_s1;
	logic             valid_s1;
	msw_pkg::result_t res_s2;
	logic             valid_s2;
	msw_pkg::result_t result;
	logic             advance;
	logic             step;

	// config register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.motion_threshold <= msw_pkg::MOTION_THRESHOLD_RST;
			cfg_q.wake_threshold   <= msw_pkg::WAKE_THRESHOLD_RST;
			cfg_q.idle_timeout_ms  <= msw_pkg::IDLE_TIMEOUT_MS_RST;
			cfg_q.wake_hits_needed <= msw_pkg::WAKE_HITS_NEEDED_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				msw_pkg::REG_MOTION_THRESHOLD: cfg_q.motion_threshold <= cfg_wdata[13:0];
				msw_pkg::REG_WAKE_THRESHOLD:   cfg_q.wake_threshold   <= cfg_wdata[13:0];
				msw_pkg::REG_IDLE_TIMEOUT_MS:  cfg_q.idle_timeout_ms  <= cfg_wdata;
				msw_pkg::REG_WAKE_HITS_NEEDED: cfg_q.wake_hits_needed <= cfg_wdata[7:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	// stage 1 moves into the result register when that register is empty or drains
	assign advance  = !valid_s2 || m_tready;
	assign step     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			sample_s1.accel_x <= s_tdata[11:0];
			sample_s1.accel_y <= s_tdata[23:12];
			sample_s1.accel_z <= s_tdata[35:24];
			sample_s1.time_ms <= s_tdata[67:36];
		end
	end

	// detector state and update
	msw_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.sample (sample_s1),
		.cfg    (cfg_q),
		.result (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {1'b0, res_s2.woke_up, res_s2.entered_sleep, res_s2.sleeping,
		res_s2.wake_distance_mg, res_s2.motion_norm};
	assign m_tuser  = res_s2.sample_invalid;

	flags_exclusive : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(res_s2.entered_sleep && res_s2.woke_up))
		else $error("sleep entry and wake in one beat");

	transition_matches_state : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((!res_s2.entered_sleep || res_s2.sleeping)
			&& (!res_s2.woke_up || !res_s2.sleeping)))
		else $error("transition flag disagrees with sleeping");

	invalid_beat_empty : assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_s2.sample_invalid) |-> (res_s2.motion_norm == 14'd0
			&& res_s2.wake_distance_mg == 14'd0 && !res_s2.entered_sleep
			&& !res_s2.woke_up))
		else $error("invalid sample produced motion or transition");

	awake_no_distance : assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !res_s2.sleeping && !res_s2.woke_up)
			|-> (res_s2.wake_distance_mg == 14'd0))
		else $error("wake distance reported while awake");

	stall_blocks_input : assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !m_tready) |-> !s_tready)
		else $error("input accepted while both stages are stalled");

endmodule

// ===== rtl/msw_core.sv =====
// ----------------------------------------------------------------------------
// msw_core
// detector state and the per-sample update: gravity filter, motion norm,
// idle timer, sleep reference and wake hit counting
// ----------------------------------------------------------------------------
module msw_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  msw_pkg::sample_t sample,
	input  msw_pkg::cfg_t    cfg,
	output msw_pkg::result_t result
);

	logic signed [11:0] grav_q [3];
	logic               grav_valid_q;
	logic signed [11:0] ref_q [3];
	logic               ref_valid_q;
	logic               asleep_q;
	logic [7:0]         hit_cnt_q;
	logic [31:0]        last_motion_q;

	logic signed [11:0] grav_n [3];
	logic               grav_valid_n;
	logic signed [11:0] ref_n [3];
	logic               ref_valid_n;
	logic               asleep_n;
	logic [7:0]         hit_cnt_n;
	logic [31:0]        last_motion_n;

	logic signed [11:0] a [3];
	logic signed [12:0] gd [3];
	logic signed [11:0] gf [3];
	logic signed [12:0] md [3];
	logic signed [12:0] rd [3];
	logic signed [11:0] rf [3];
	logic [14:0]        motion;
	logic [14:0]        ref_dist;
	logic [31:0]        idle;
	logic               invalid;
	logic               hit;
	logic               entered;
	logic               woke;

	// filter arithmetic per axis
	always_comb begin
		a[0] = sample.accel_x;
		a[1] = sample.accel_y;
		a[2] = sample.accel_z;
		for (int i = 0; i < 3; i++) begin
			gd[i] = 13'(a[i]) - 13'(grav_q[i]);
			gf[i] = 12'(13'(grav_q[i]) + msw_pkg::shr_trunc(gd[i], msw_pkg::GRAV_SHIFT));
			md[i] = 13'(a[i]) - 13'(gf[i]);
			rd[i] = 13'(a[i]) - 13'(ref_q[i]);
			rf[i] = 12'(13'(ref_q[i]) + msw_pkg::shr_trunc(rd[i], msw_pkg::REF_SHIFT));
		end
		invalid = (a[0] == 12'sd0) && (a[1] == 12'sd0) && (a[2] == 12'sd0);
	end

	// next state
	always_comb begin
		grav_n        = grav_q;
		grav_valid_n  = grav_valid_q;
		ref_n         = ref_q;
		ref_valid_n   = ref_valid_q;
		asleep_n      = asleep_q;
		hit_cnt_n     = hit_cnt_q;
		last_motion_n = last_motion_q;
		motion        = '0;
		ref_dist      = '0;
		idle          = '0;
		hit           = 1'b0;
		entered       = 1'b0;
		woke          = 1'b0;

		if (invalid) begin
			grav_valid_n = 1'b0;
			ref_valid_n  = 1'b0;
		end else begin
			// gravity: seed on first sample, else 1/16 step and L1 remainder
			if (!grav_valid_q) begin
				grav_n       = a;
				grav_valid_n = 1'b1;
			end else begin
				grav_n = gf;
				motion = 15'(msw_pkg::abs13(md[0])) + 15'(msw_pkg::abs13(md[1]))
					+ 15'(msw_pkg::abs13(md[2]));
			end

			if (asleep_q) begin
				if (!ref_valid_q) begin
					ref_n       = a;
					ref_valid_n = 1'b1;
				end else begin
					ref_dist = 15'(msw_pkg::abs13(rd[0])) + 15'(msw_pkg::abs13(rd[1]))
						+ 15'(msw_pkg::abs13(rd[2]));
					if (ref_dist < 15'(cfg.wake_threshold)) begin
						ref_n = rf;
					end else begin
						hit = 1'b1;
					end
				end
				if (hit) begin
					if (hit_cnt_q != msw_pkg::HIT_CNT_MAX) begin
						hit_cnt_n = hit_cnt_q + 8'd1;
					end
				end else begin
					hit_cnt_n = '0;
				end
				if (hit_cnt_n >= cfg.wake_hits_needed) begin
					asleep_n      = 1'b0;
					hit_cnt_n     = '0;
					ref_valid_n   = 1'b0;
					grav_valid_n  = 1'b0;
					last_motion_n = sample.time_ms;
					woke          = 1'b1;
				end
			end else begin
				if (motion > 15'(cfg.motion_threshold)) begin
					last_motion_n = sample.time_ms;
				end
				idle = sample.time_ms - last_motion_n;
				if (idle >= cfg.idle_timeout_ms) begin
					asleep_n    = 1'b1;
					hit_cnt_n   = '0;
					ref_valid_n = 1'b0;
					entered     = 1'b1;
				end
			end
		end
	end

	// result fields
	always_comb begin
		result.motion_norm      = motion[13:0];
		result.wake_distance_mg = ref_dist[13:0];
		result.sleeping         = asleep_n;
		result.entered_sleep    = entered;
		result.woke_up          = woke;
		result.sample_invalid   = invalid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				grav_q[i] <= '0;
				ref_q[i]  <= '0;
			end
			grav_valid_q  <= 1'b0;
			ref_valid_q   <= 1'b0;
			asleep_q      <= 1'b0;
			hit_cnt_q     <= '0;
			last_motion_q <= '0;
		end else if (step) begin
			grav_q        <= grav_n;
			ref_q         <= ref_n;
			grav_valid_q  <= grav_valid_n;
			ref_valid_q   <= ref_valid_n;
			asleep_q      <= asleep_n;
			hit_cnt_q     <= hit_cnt_n;
			last_motion_q <= last_motion_n;
		end
	end

	wake_on_count : assert property (@(posedge clk) disable iff (!arst_n)
		(step && asleep_q && !invalid && hit_cnt_n >= cfg.wake_hits_needed) |=> !asleep_q)
		else $error("wake count reached but still asleep");

	invalid_keeps_state : assert property (@(posedge clk) disable iff (!arst_n)
		(step && invalid) |=> (!grav_valid_q && !ref_valid_q && $stable(asleep_q)
			&& $stable(last_motion_q)))
		else $error("invalid sample changed detector state");

	count_clear_awake : assert property (@(posedge clk) disable iff (!arst_n)
		!asleep_q |-> (hit_cnt_q == 8'd0))
		else $error("wake hit count nonzero while awake");

endmodule

// ===== tb/motion_sleep_wake_detector_unit_tb.sv =====
// ----------------------------------------------------------------------------
// motion_sleep_wake_detector_unit_tb
// self-checking bench for the motion sleep/wake detector: a queue-fed driver
// sends acceleration samples in random bursts, a monitor predicts every
// result and compares it field by field with the output beats
// ----------------------------------------------------------------------------
module motion_sleep_wake_detector_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// cycles with no beat on either side before the run is abandoned
	localparam int unsigned QUIET_LIMIT = 4000;

	typedef enum int {RDY_ALWAYS, RDY_MOSTLY, RDY_SELDOM, RDY_TOGGLE} ready_mode_t;
	typedef enum int {SEG_STILL, SEG_SHAKE, SEG_NOISE, SEG_INVALID, SEG_REBASE} segment_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata = '0;   // accel_x, accel_y, accel_z, time_ms, pad
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;        // motion_norm, wake_distance_mg, sleeping, entered, woke, pad
	logic        m_tuser;        // sample_invalid
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_wdata = '0;

	motion_sleep_wake_detector_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// samples waiting for the driver, results waiting for the monitor
	msw_pkg::sample_t sample_queue[$];
	msw_pkg::result_t pending_results[$];
	int unsigned n_queued = 0;      // samples handed to the driver
	int unsigned n_driven = 0;      // samples put on the bus
	int unsigned n_in_beats = 0;    // samples accepted by the block
	int unsigned out_beats = 0;
	int unsigned mismatch_count = 0;
	int unsigned quiet_cycles = 0;

	// ------------------------------------------------------------------
	// detector model: register copies and state
	// ------------------------------------------------------------------
	logic [13:0] motion_thr_q   = msw_pkg::MOTION_THRESHOLD_RST;
	logic [13:0] wake_thr_q     = msw_pkg::WAKE_THRESHOLD_RST;
	logic [31:0] idle_to_q      = msw_pkg::IDLE_TIMEOUT_MS_RST;
	logic [7:0]  hits_needed_q  = msw_pkg::WAKE_HITS_NEEDED_RST;

	int          gravity_est[3] = '{0, 0, 0};
	bit          gravity_ok = 1'b0;
	int          wake_ref[3] = '{0, 0, 0};
	bit          wake_ref_ok = 1'b0;
	bit          asleep_q = 1'b0;
	int unsigned hit_cnt = 0;
	logic [31:0] last_motion_ms = '0;

	// signed divide by 2^k, rounding toward zero
	function automatic int shr_toward_zero(input int d, input int k);
		if (d < 0) begin
			return -((-d) >>> k);
		end
		return d >>> k;
	endfunction

	function automatic int abs_int(input int d);
		return (d < 0) ? -d : d;
	endfunction

	task automatic predict_detector(input msw_pkg::sample_t smp,
			output msw_pkg::result_t res);
		int          a[3];
		int          motion;
		int          ref_dist;
		bit          hit;
		logic [31:0] idle_ms;
		a[0] = $signed(smp.accel_x);
		a[1] = $signed(smp.accel_y);
		a[2] = $signed(smp.accel_z);
		motion = 0;
		ref_dist = 0;
		hit = 1'b0;
		res = '0;

		// all-zero sample: only the filter-valid flags are dropped
		if (a[0] == 0 && a[1] == 0 && a[2] == 0) begin
			gravity_ok = 1'b0;
			wake_ref_ok = 1'b0;
			res.sleeping = asleep_q;
			res.sample_invalid = 1'b1;
			return;
		end

		// gravity tracking, the first sample seeds it and reports no motion
		if (!gravity_ok) begin
			for (int i = 0; i < 3; i++) gravity_est[i] = a[i];
			gravity_ok = 1'b1;
		end else begin
			for (int i = 0; i < 3; i++) begin
				gravity_est[i] += shr_toward_zero(a[i] - gravity_est[i],
					int'(msw_pkg::GRAV_SHIFT));
				motion += abs_int(a[i] - gravity_est[i]);
			end
		end

		if (asleep_q) begin
			// no reference yet: seed it and count a miss
			if (!wake_ref_ok) begin
				for (int i = 0; i < 3; i++) wake_ref[i] = a[i];
				wake_ref_ok = 1'b1;
			end else begin
				for (int i = 0; i < 3; i++) ref_dist += abs_int(a[i] - wake_ref[i]);
				if (ref_dist < int'(wake_thr_q)) begin
					for (int i = 0; i < 3; i++) begin
						wake_ref[i] += shr_toward_zero(a[i] - wake_ref[i],
							int'(msw_pkg::REF_SHIFT));
					end
				end else begin
					hit = 1'b1;
				end
			end
			if (hit) begin
				if (hit_cnt < 255) hit_cnt++;
			end else begin
				hit_cnt = 0;
			end
			if (hit_cnt >= hits_needed_q) begin
				asleep_q = 1'b0;
				hit_cnt = 0;
				wake_ref_ok = 1'b0;
				gravity_ok = 1'b0;
				last_motion_ms = smp.time_ms;
				res.woke_up = 1'b1;
			end
		end else begin
			if (motion > int'(motion_thr_q)) last_motion_ms = smp.time_ms;
			idle_ms = smp.time_ms - last_motion_ms;
			if (idle_ms >= idle_to_q) begin
				asleep_q = 1'b1;
				hit_cnt = 0;
				wake_ref_ok = 1'b0;
				res.entered_sleep = 1'b1;
			end
		end

		res.motion_norm = motion[13:0];
		res.wake_distance_mg = ref_dist[13:0];
		res.sleeping = asleep_q;
	endtask

	// ------------------------------------------------------------------
	// mismatch reporting
	// ------------------------------------------------------------------
	task automatic flag_error(input string msg);
		$display("[%0t] out beat %0d: %s", $time, out_beats, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input int unsigned got,
			input int unsigned want);
		if (got != want) begin
			flag_error($sformatf("%s got %0d expected %0d", name, got, want));
		end
	endtask

	// ------------------------------------------------------------------
	// driver: bursts of samples with random gaps, changes on falling edge
	// ------------------------------------------------------------------
	int unsigned burst_left = 1;
	int unsigned gap_left = 0;

	always @(negedge clk) begin : drive_samples
		msw_pkg::sample_t smp;
		if (arst_n) begin
			if (s_tvalid && n_in_beats != n_driven) begin
				// beat still waiting for s_tready, hold it
			end else if (gap_left > 0) begin
				s_tvalid <= 1'b0;
				gap_left--;
			end else if (sample_queue.size() > 0) begin
				smp = sample_queue.pop_front();
				s_tdata <= {4'b0, smp.time_ms, smp.accel_z, smp.accel_y, smp.accel_x};
				s_tvalid <= 1'b1;
				n_driven++;
				if (burst_left > 0) burst_left--;
				if (burst_left == 0) begin
					// now and then a long run with no gaps
					burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 300)
						: $urandom_range(1, 20);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// receiver backpressure, mode picked at random for each run of random length
	// ------------------------------------------------------------------
	ready_mode_t ready_mode = RDY_ALWAYS;
	int unsigned ready_left = 0;

	always @(negedge clk) begin
		if (ready_left == 0) begin
			ready_mode = ready_mode_t'($urandom_range(0, 3));
			ready_left = $urandom_range(8, 150);
		end
		ready_left--;
		case (ready_mode)
			RDY_ALWAYS: m_tready <= 1'b1;
			RDY_MOSTLY: m_tready <= ($urandom_range(0, 9) < 7);
			RDY_SELDOM: m_tready <= ($urandom_range(0, 9) < 3);
			default:    m_tready <= ~m_tready;
		endcase
	end

	// ------------------------------------------------------------------
	// monitor: checks output beats, predicts accepted samples, watchdog
	// ------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		msw_pkg::sample_t smp;
		msw_pkg::result_t want;
		msw_pkg::result_t pred;
		logic    progress;
		progress = 1'b0;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				progress = 1'b1;
				if (pending_results.size() == 0) begin
					flag_error("result beat with nothing expected");
				end else begin
					want = pending_results.pop_front();
					check_field("motion_norm", m_tdata[13:0], want.motion_norm);
					check_field("wake_distance_mg", m_tdata[27:14], want.wake_distance_mg);
					check_field("sleeping", m_tdata[28], want.sleeping);
					check_field("entered_sleep", m_tdata[29], want.entered_sleep);
					check_field("woke_up", m_tdata[30], want.woke_up);
					check_field("sample_invalid", m_tuser, want.sample_invalid);
				end
				out_beats++;
			end
			if (s_tvalid && s_tready) begin
				progress = 1'b1;
				smp.accel_x = s_tdata[11:0];
				smp.accel_y = s_tdata[23:12];
				smp.accel_z = s_tdata[35:24];
				smp.time_ms = s_tdata[67:36];
				predict_detector(smp, pred);
				pending_results.push_back(pred);
				n_in_beats++;
			end
		end
		if (progress) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[motion_sleep_wake_detector_unit] ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	logic [31:0] stim_time = '0;
	int          base_v[3] = '{0, 0, 1000};

	function automatic int clamp12(input int v);
		if (v > 2047) return 2047;
		if (v < -2048) return -2048;
		return v;
	endfunction

	task automatic push_sample(input int x, input int y, input int z, input logic [31:0] t);
		msw_pkg::sample_t smp;
		smp.accel_x = 12'(clamp12(x));
		smp.accel_y = 12'(clamp12(y));
		smp.accel_z = 12'(clamp12(z));
		smp.time_ms = t;
		sample_queue.push_back(smp);
		n_queued++;
	endtask

	// block idle: every sample accepted and every result out
	task automatic drain();
		while (n_in_beats != n_queued || pending_results.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		case (idx)
			msw_pkg::REG_MOTION_THRESHOLD: motion_thr_q = data[13:0];
			msw_pkg::REG_WAKE_THRESHOLD:   wake_thr_q = data[13:0];
			msw_pkg::REG_IDLE_TIMEOUT_MS:  idle_to_q = data;
			msw_pkg::REG_WAKE_HITS_NEEDED: hits_needed_q = data[7:0];
			default:                       ;
		endcase
	endtask

	task automatic apply_setting(input logic [31:0] motion_thr, input logic [31:0] wake_thr,
			input logic [31:0] idle_to, input logic [31:0] hits);
		drain();
		write_reg(msw_pkg::REG_MOTION_THRESHOLD, motion_thr);
		write_reg(msw_pkg::REG_WAKE_THRESHOLD, wake_thr);
		write_reg(msw_pkg::REG_IDLE_TIMEOUT_MS, idle_to);
		write_reg(msw_pkg::REG_WAKE_HITS_NEEDED, hits);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// time advance scaled to the idle timeout so that sleep is reachable
	function automatic logic [31:0] time_step();
		logic [31:0] span;
		span = idle_to_q >> 2;
		if (span > 32'h0010_0000) span = 32'h0010_0000;
		return $urandom_range(0, span + 2);
	endfunction

	function automatic int shake_offset();
		int mag;
		mag = $urandom_range(100, 1500);
		return ($urandom_range(0, 1) != 0) ? mag : -mag;
	endfunction

	// random segments: still runs lead to sleep, shake runs to wake,
	// the rest is noise, invalid samples and orientation changes
	task automatic run_random(input int unsigned n_items);
		int unsigned stop_at;
		int unsigned len;
		int          amp;
		int          pick;
		int          r[3];
		segment_t    seg;
		stop_at = n_queued + n_items;
		while (n_queued < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) seg = SEG_STILL;
			else if (pick < 65) seg = SEG_SHAKE;
			else if (pick < 80) seg = SEG_NOISE;
			else if (pick < 87) seg = SEG_INVALID;
			else seg = SEG_REBASE;
			case (seg)
				SEG_STILL: begin
					len = $urandom_range(5, 40);
					amp = $urandom_range(0, 6);
					repeat (len) begin
						stim_time += time_step();
						for (int i = 0; i < 3; i++) begin
							r[i] = $urandom_range(0, 2 * amp);
							r[i] = base_v[i] + r[i] - amp;
						end
						push_sample(r[0], r[1], r[2], stim_time);
					end
				end
				SEG_SHAKE: begin
					// half of the runs exceed the wake hit count by one to three samples
					len = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 12)
						: hits_needed_q + $urandom_range(1, 3);
					repeat (len) begin
						stim_time += $urandom_range(0, 20);
						push_sample(base_v[0] + shake_offset(), base_v[1] + shake_offset(),
							base_v[2] + shake_offset(), stim_time);
					end
				end
				SEG_NOISE: begin
					len = $urandom_range(1, 4);
					repeat (len) begin
						if ($urandom_range(0, 1) != 0) stim_time = $urandom;
						else stim_time += time_step();
						for (int i = 0; i < 3; i++) begin
							r[i] = $urandom_range(0, 4095);
							r[i] = r[i] - 2048;
						end
						push_sample(r[0], r[1], r[2], stim_time);
					end
				end
				SEG_INVALID: begin
					stim_time += time_step();
					push_sample(0, 0, 0, stim_time);
				end
				default: begin
					for (int i = 0; i < 3; i++) begin
						r[i] = $urandom_range(0, 2400);
						base_v[i] = r[i] - 1200;
					end
				end
			endcase
		end
	endtask

	// ------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset register values: seeding, extremes, invalid, sleep and wake
		push_sample(0, 0, 1000, 32'd0);
		push_sample(2047, -2048, 2047, 32'd10);
		push_sample(-2048, 2047, -2048, 32'd20);
		push_sample(0, 0, 0, 32'd30);
		push_sample(0, 0, 1000, 32'd40);
		push_sample(3, -2, 1001, 32'd60020);       // idle reaches the timeout
		push_sample(1, 1, 999, 32'd60030);         // seeds the wake reference
		push_sample(6, 6, 1006, 32'd60040);        // miss, reference creeps
		push_sample(0, 0, 0, 32'd60050);           // invalid while asleep
		push_sample(0, 0, 1000, 32'd60060);        // reseeds both filters
		push_sample(400, -300, 1000, 32'd60070);   // hit, wakes
		push_sample(0, 0, 1000, 32'hFFFF_FFF0);
		push_sample(0, 0, 1000, 32'h0000_0010);    // timestamp wrapped
		push_sample(2047, 2047, 2047, 32'h0000_0020);
		push_sample(-2048, -2048, -2048, 32'h0000_0030);
		stim_time = 32'h0000_0030;
		run_random(165);

		// lowest settings: zero timeout sleeps at once, zero hits wakes at once
		apply_setting(32'd0, 32'd0, 32'd0, 32'd0);
		push_sample(0, 0, 1, stim_time + 1);
		push_sample(-2048, -2048, -2048, stim_time + 2);
		push_sample(2047, 2047, 2047, stim_time + 3);
		push_sample(0, 0, 0, stim_time + 4);
		push_sample(5, 5, 5, stim_time + 5);
		stim_time += 5;
		run_random(165);
		drain();
		if (asleep_q) begin
			stim_time += 1;
			push_sample(50, 50, 50, stim_time);
		end

		// highest settings: sleep only on an idle span of all ones
		apply_setting(32'd12288, 32'd12288, 32'hFFFF_FFFF, 32'd255);
		push_sample(100, 100, 100, last_motion_ms - 32'd2);
		push_sample(100, 100, 100, last_motion_ms - 32'd1);
		stim_time = last_motion_ms - 32'd1;
		run_random(165);

		// long hit runs needed to wake
		apply_setting(32'd80, 32'd20, 32'd50, 32'd255);
		run_random(400);

		repeat (4) begin
			apply_setting($urandom_range(10, 300), $urandom_range(5, 400),
				$urandom_range(0, 3000), $urandom_range(1, 6));
			run_random(165);
		end

		drain();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("[motion_sleep_wake_detector_unit] OK");
		end else begin
			$display("[motion_sleep_wake_detector_unit] ERROR");
		end
		$finish;
	end

endmodule
